@@ sv/multicast_group_membership_table_macros.svh @@
// assertion macros for the multicast group membership table
// used by the top level; expects clk and rst_n in scope
`ifndef MULTICAST_GROUP_MEMBERSHIP_TABLE_MACROS_SVH
`define MULTICAST_GROUP_MEMBERSHIP_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MGMT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MGMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mgmt_pkg.sv @@
// shared constants and codes for the multicast group membership table
// no dependencies
`default_nettype none

package mgmt_pkg;

    localparam int MAX_GROUPS_DEF    = 16;
    localparam int MAX_RECEIVERS_DEF = 16;
    localparam int MAX_RESULTS       = 16;

    localparam logic [23:0] MCAST_OUI = 24'h01005E;

    // command codes
    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_JOIN      = 3'd1;
    localparam logic [2:0] CMD_LEAVE     = 3'd2;
    localparam logic [2:0] CMD_LEAVE_ALL = 3'd3;
    localparam logic [2:0] CMD_LOOKUP    = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // compare unit modes
    typedef enum logic [1:0] {
        CMP_IP,
        CMP_MAC,
        CMP_STA
    } cmp_mode_t;

endpackage

`default_nettype wire

@@ sv/mgmt_cmp.sv @@
// shared equality compare unit: group ip, group mac or station
// depends on mgmt_pkg
`default_nettype none

module mgmt_cmp (
    input  wire mgmt_pkg::cmp_mode_t mode,
    input  wire logic [31:0]         group_ip,
    input  wire logic [47:0]         station,
    input  wire logic [47:0]         lookup_mac,
    input  wire logic [31:0]         entry_ip,
    input  wire logic [47:0]         entry_sta,
    output logic                     match
);

    logic [47:0] key;
    logic [47:0] cand;

    // select key and candidate per mode
    always_comb
    begin
        case (mode)
            mgmt_pkg::CMP_IP:
            begin
                key  = {16'd0, group_ip};
                cand = {16'd0, entry_ip};
            end
            mgmt_pkg::CMP_MAC:
            begin
                key  = lookup_mac;
                cand = {mgmt_pkg::MCAST_OUI, 1'b0, entry_ip[22:0]};
            end
            default:
            begin
                key  = station;
                cand = entry_sta;
            end
        endcase
    end

    assign match = (key == cand);

endmodule

`default_nettype wire

@@ sv/mgmt_mem.sv @@
// group and member storage, one write and one registered read per memory
// depends on nothing but its parameters
`default_nettype none

module mgmt_mem #(
    parameter int MAX_GROUPS    = 16,
    parameter int MAX_RECEIVERS = 16,
    parameter int GW  = 4,
    parameter int CW  = 5,
    parameter int MAW = 8
) (
    input  wire logic           clk,
    input  wire logic [GW-1:0]  g_rd_addr,
    output logic [31:0]         g_rd_ip,
    output logic [CW-1:0]       g_rd_cnt,
    input  wire logic           g_we,
    input  wire logic [GW-1:0]  g_wr_addr,
    input  wire logic [31:0]    g_wr_ip,
    input  wire logic [CW-1:0]  g_wr_cnt,
    input  wire logic [MAW-1:0] m_rd_addr,
    output logic [47:0]         m_rd_data,
    input  wire logic           m_we,
    input  wire logic [MAW-1:0] m_wr_addr,
    input  wire logic [47:0]    m_wr_data
);

    logic [31:0]   gip_mem  [MAX_GROUPS];
    logic [CW-1:0] gcnt_mem [MAX_GROUPS];
    logic [47:0]   mem_mem  [MAX_GROUPS*MAX_RECEIVERS];

    // group table
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gip_mem[g_wr_addr]  <= g_wr_ip;
            gcnt_mem[g_wr_addr] <= g_wr_cnt;
        end
        g_rd_ip  <= gip_mem[g_rd_addr];
        g_rd_cnt <= gcnt_mem[g_rd_addr];
    end

    // member lists
    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mem_mem[m_wr_addr] <= m_wr_data;
        end
        m_rd_data <= mem_mem[m_rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/multicast_group_membership_table.sv @@
// multicast group membership table: sequencer over one shared compare unit
// a command searches the groups in turn, scans a group's receivers in turn, shifts later entries
// down on removal, and moves every later group and its member list down when a group is deleted
// result words are registered; lookup sends one word per receiver found, up to MAX_RESULTS
// one command at a time, busy covers the whole walk; result words are never stalled
// reset clears the group count and sequencer; memory contents are not cleared
`default_nettype none

module multicast_group_membership_table #(
    parameter int MAX_GROUPS    = mgmt_pkg::MAX_GROUPS_DEF,
    parameter int MAX_RECEIVERS = mgmt_pkg::MAX_RECEIVERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] group_ip,
    input  wire logic [47:0] station,
    input  wire logic [47:0] lookup_mac,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [47:0]      receiver,
    output logic             receiver_valid,
    output logic             last
);

    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int KW  = $clog2(MAX_GROUPS + 1);
    localparam int CW  = $clog2(MAX_RECEIVERS + 1);
    localparam int MAW = (MAX_GROUPS * MAX_RECEIVERS > 1) ?
                         $clog2(MAX_GROUPS * MAX_RECEIVERS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_GS_RD, S_GS_CHK, S_LA_TOP, S_LA_CHK, S_MS_RD, S_MS_CHK,
        S_DM_RD, S_DM_WR, S_DG_TOP, S_DG_GW, S_DG_MRD, S_DG_MWR, S_LO_RD, S_LO_OUT
    } state_t;

    state_t        state_reg;
    logic [2:0]    cmd_reg;
    logic [31:0]   ip_reg;
    logic [47:0]   sta_reg;
    logic [47:0]   lmac_reg;
    logic [KW-1:0] gcnt_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] d_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] cur_cnt_reg;
    logic [CW-1:0] n_reg;
    logic [31:0]   cur_ip_reg;
    logic          result_valid_reg;
    logic [1:0]    status_reg;
    logic [47:0]   receiver_reg;
    logic          receiver_valid_reg;
    logic          last_reg;

    logic [GW-1:0]       g_rd_addr;
    logic [31:0]         g_rd_ip;
    logic [CW-1:0]       g_rd_cnt;
    logic                g_we;
    logic [GW-1:0]       g_wr_addr;
    logic [31:0]         g_wr_ip;
    logic [CW-1:0]       g_wr_cnt;
    logic [MAW-1:0]      m_rd_addr;
    logic [47:0]         m_rd_data;
    logic                m_we;
    logic [MAW-1:0]      m_wr_addr;
    logic [47:0]         m_wr_data;
    mgmt_pkg::cmp_mode_t cmp_mode;
    logic                cmp_match;
    logic [KW-1:0]       d_inc;
    logic [CW:0]         j_inc;

    function automatic logic [MAW-1:0] maddr(input logic [GW-1:0] g, input logic [CW-1:0] j);
        return MAW'(g) * MAW'(MAX_RECEIVERS) + MAW'(j);
    endfunction

    assign d_inc = d_reg + KW'(1);
    assign j_inc = {1'b0, j_reg} + (CW+1)'(1);

    mgmt_mem #(
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_RECEIVERS (MAX_RECEIVERS),
        .GW            (GW),
        .CW            (CW),
        .MAW           (MAW)
    ) u_mem (
        .clk       (clk),
        .g_rd_addr (g_rd_addr),
        .g_rd_ip   (g_rd_ip),
        .g_rd_cnt  (g_rd_cnt),
        .g_we      (g_we),
        .g_wr_addr (g_wr_addr),
        .g_wr_ip   (g_wr_ip),
        .g_wr_cnt  (g_wr_cnt),
        .m_rd_addr (m_rd_addr),
        .m_rd_data (m_rd_data),
        .m_we      (m_we),
        .m_wr_addr (m_wr_addr),
        .m_wr_data (m_wr_data)
    );

    mgmt_cmp u_cmp (
        .mode       (cmp_mode),
        .group_ip   (ip_reg),
        .station    (sta_reg),
        .lookup_mac (lmac_reg),
        .entry_ip   (g_rd_ip),
        .entry_sta  (m_rd_data),
        .match      (cmp_match)
    );

    // memory addressing and writes per sequencer step
    always_comb
    begin
        g_rd_addr = '0;
        g_we      = 1'b0;
        g_wr_addr = '0;
        g_wr_ip   = cur_ip_reg;
        g_wr_cnt  = '0;
        m_rd_addr = '0;
        m_we      = 1'b0;
        m_wr_addr = '0;
        m_wr_data = m_rd_data;
        cmp_mode  = mgmt_pkg::CMP_STA;
        unique case (state_reg)
            S_GS_RD:
            begin
                g_rd_addr = k_reg[GW-1:0];
                if (k_reg == gcnt_reg && cmd_reg == mgmt_pkg::CMD_ADD &&
                    gcnt_reg < KW'(MAX_GROUPS))
                begin
                    g_we      = 1'b1;
                    g_wr_addr = gcnt_reg[GW-1:0];
                    g_wr_ip   = ip_reg;
                end
            end
            S_GS_CHK:
            begin
                cmp_mode = (cmd_reg == mgmt_pkg::CMD_LOOKUP) ?
                           mgmt_pkg::CMP_MAC : mgmt_pkg::CMP_IP;
            end
            S_LA_TOP:
            begin
                g_rd_addr = k_reg[GW-1:0];
            end
            S_MS_RD:
            begin
                m_rd_addr = maddr(k_reg[GW-1:0], j_reg);
                if (j_reg == cur_cnt_reg && cmd_reg == mgmt_pkg::CMD_JOIN &&
                    cur_cnt_reg < CW'(MAX_RECEIVERS))
                begin
                    m_we      = 1'b1;
                    m_wr_addr = maddr(k_reg[GW-1:0], cur_cnt_reg);
                    m_wr_data = sta_reg;
                    g_we      = 1'b1;
                    g_wr_addr = k_reg[GW-1:0];
                    g_wr_cnt  = cur_cnt_reg + CW'(1);
                end
            end
            S_DM_RD:
            begin
                m_rd_addr = maddr(k_reg[GW-1:0], j_inc[CW-1:0]);
                if (j_inc >= {1'b0, cur_cnt_reg} && cur_cnt_reg != CW'(1))
                begin
                    g_we      = 1'b1;
                    g_wr_addr = k_reg[GW-1:0];
                    g_wr_cnt  = cur_cnt_reg - CW'(1);
                end
            end
            S_DM_WR:
            begin
                m_we      = 1'b1;
                m_wr_addr = maddr(k_reg[GW-1:0], j_reg);
            end
            S_DG_TOP:
            begin
                g_rd_addr = d_inc[GW-1:0];
            end
            S_DG_GW:
            begin
                g_we      = 1'b1;
                g_wr_addr = d_reg[GW-1:0];
                g_wr_ip   = g_rd_ip;
                g_wr_cnt  = g_rd_cnt;
            end
            S_DG_MRD:
            begin
                m_rd_addr = maddr(d_inc[GW-1:0], j_reg);
            end
            S_DG_MWR:
            begin
                m_we      = 1'b1;
                m_wr_addr = maddr(d_reg[GW-1:0], j_reg);
            end
            S_LO_RD:
            begin
                m_rd_addr = maddr(k_reg[GW-1:0], j_reg);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and result word registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            gcnt_reg           <= '0;
            cmd_reg            <= '0;
            ip_reg             <= '0;
            sta_reg            <= '0;
            lmac_reg           <= '0;
            k_reg              <= '0;
            d_reg              <= '0;
            j_reg              <= '0;
            cur_cnt_reg        <= '0;
            n_reg              <= '0;
            cur_ip_reg         <= '0;
            result_valid_reg   <= 1'b0;
            status_reg         <= '0;
            receiver_reg       <= '0;
            receiver_valid_reg <= 1'b0;
            last_reg           <= 1'b0;
        end
        else
        begin
            result_valid_reg   <= 1'b0;
            status_reg         <= mgmt_pkg::ST_DONE;
            receiver_reg       <= '0;
            receiver_valid_reg <= 1'b0;
            last_reg           <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg  <= cmd;
                        ip_reg   <= group_ip;
                        sta_reg  <= station;
                        lmac_reg <= lookup_mac;
                        k_reg    <= '0;
                        case (cmd) inside
                            mgmt_pkg::CMD_ADD, mgmt_pkg::CMD_JOIN, mgmt_pkg::CMD_LEAVE,
                            mgmt_pkg::CMD_LOOKUP:
                                state_reg <= S_GS_RD;
                            mgmt_pkg::CMD_LEAVE_ALL:
                                state_reg <= S_LA_TOP;
                            default:
                            begin
                                result_valid_reg <= 1'b1;
                                status_reg       <= mgmt_pkg::ST_NOT_FOUND;
                            end
                        endcase
                    end
                end
                S_GS_RD:
                begin
                    if (k_reg == gcnt_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                        if (cmd_reg == mgmt_pkg::CMD_ADD)
                        begin
                            if (gcnt_reg >= KW'(MAX_GROUPS))
                            begin
                                status_reg <= mgmt_pkg::ST_FULL;
                            end
                            else
                            begin
                                gcnt_reg   <= gcnt_reg + KW'(1);
                                status_reg <= mgmt_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            status_reg <= mgmt_pkg::ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        state_reg <= S_GS_CHK;
                    end
                end
                S_GS_CHK:
                begin
                    if (cmp_match)
                    begin
                        cur_ip_reg  <= g_rd_ip;
                        cur_cnt_reg <= g_rd_cnt;
                        j_reg       <= '0;
                        if (cmd_reg == mgmt_pkg::CMD_ADD)
                        begin
                            result_valid_reg <= 1'b1;
                            status_reg       <= mgmt_pkg::ST_PRESENT;
                            state_reg        <= S_IDLE;
                        end
                        else if (cmd_reg == mgmt_pkg::CMD_LOOKUP)
                        begin
                            if (g_rd_cnt == '0)
                            begin
                                result_valid_reg <= 1'b1;
                                state_reg        <= S_IDLE;
                            end
                            else
                            begin
                                n_reg     <= (int'(g_rd_cnt) > mgmt_pkg::MAX_RESULTS) ?
                                             CW'(mgmt_pkg::MAX_RESULTS) : g_rd_cnt;
                                state_reg <= S_LO_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_MS_RD;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_GS_RD;
                    end
                end
                S_LA_TOP:
                begin
                    if (k_reg == gcnt_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_LA_CHK;
                    end
                end
                S_LA_CHK:
                begin
                    cur_ip_reg  <= g_rd_ip;
                    cur_cnt_reg <= g_rd_cnt;
                    j_reg       <= '0;
                    state_reg   <= S_MS_RD;
                end
                S_MS_RD:
                begin
                    if (j_reg == cur_cnt_reg)
                    begin
                        if (cmd_reg == mgmt_pkg::CMD_LEAVE_ALL)
                        begin
                            k_reg     <= k_reg + KW'(1);
                            state_reg <= S_LA_TOP;
                        end
                        else
                        begin
                            result_valid_reg <= 1'b1;
                            state_reg        <= S_IDLE;
                            if (cmd_reg == mgmt_pkg::CMD_JOIN)
                            begin
                                status_reg <= (cur_cnt_reg >= CW'(MAX_RECEIVERS)) ?
                                              mgmt_pkg::ST_FULL : mgmt_pkg::ST_DONE;
                            end
                            else
                            begin
                                status_reg <= mgmt_pkg::ST_NOT_FOUND;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= S_MS_CHK;
                    end
                end
                S_MS_CHK:
                begin
                    if (cmp_match)
                    begin
                        if (cmd_reg == mgmt_pkg::CMD_JOIN)
                        begin
                            result_valid_reg <= 1'b1;
                            status_reg       <= mgmt_pkg::ST_PRESENT;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DM_RD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_inc[CW-1:0];
                        state_reg <= S_MS_RD;
                    end
                end
                S_DM_RD:
                begin
                    if (j_inc < {1'b0, cur_cnt_reg})
                    begin
                        state_reg <= S_DM_WR;
                    end
                    else if (cur_cnt_reg == CW'(1))
                    begin
                        d_reg     <= k_reg;
                        state_reg <= S_DG_TOP;
                    end
                    else if (cmd_reg == mgmt_pkg::CMD_LEAVE)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_LA_TOP;
                    end
                end
                S_DM_WR:
                begin
                    j_reg     <= j_inc[CW-1:0];
                    state_reg <= S_DM_RD;
                end
                S_DG_TOP:
                begin
                    if (d_inc < gcnt_reg)
                    begin
                        state_reg <= S_DG_GW;
                    end
                    else
                    begin
                        gcnt_reg <= gcnt_reg - KW'(1);
                        if (cmd_reg == mgmt_pkg::CMD_LEAVE)
                        begin
                            result_valid_reg <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_LA_TOP;
                        end
                    end
                end
                S_DG_GW:
                begin
                    j_reg     <= '0;
                    state_reg <= S_DG_MRD;
                end
                S_DG_MRD:
                begin
                    if (j_reg == CW'(MAX_RECEIVERS))
                    begin
                        d_reg     <= d_inc;
                        state_reg <= S_DG_TOP;
                    end
                    else
                    begin
                        state_reg <= S_DG_MWR;
                    end
                end
                S_DG_MWR:
                begin
                    j_reg     <= j_inc[CW-1:0];
                    state_reg <= S_DG_MRD;
                end
                S_LO_RD:
                begin
                    state_reg <= S_LO_OUT;
                end
                S_LO_OUT:
                begin
                    result_valid_reg   <= 1'b1;
                    receiver_reg       <= m_rd_data;
                    receiver_valid_reg <= 1'b1;
                    if (j_inc == {1'b0, n_reg})
                    begin
                        last_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        last_reg  <= 1'b0;
                        j_reg     <= j_inc[CW-1:0];
                        state_reg <= S_LO_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign receiver       = receiver_reg;
    assign receiver_valid = receiver_valid_reg;
    assign last           = last_reg;

    `include "multicast_group_membership_table_macros.svh"

    // a word without last is followed by more work
    `MGMT_ASSERT_NEXT(a_more_after_not_last, result_valid && !last, busy, "idle after non-last word")
    // finishing a command always delivers its final word
    `MGMT_ASSERT_SAME(a_finish_has_last, $fell(busy), result_valid && last, "command ended without last word")
    // receivers only come with done status
    `MGMT_ASSERT_SAME(a_rcv_status, result_valid && receiver_valid, status == mgmt_pkg::ST_DONE, "receiver with bad status")
    // group count stays within the table
    `MGMT_ASSERT_SAME(a_gcnt_range, 1'b1, gcnt_reg <= KW'(MAX_GROUPS), "group count overflow")

endmodule

`default_nettype wire
